// ===== design/soa_pkg.sv =====
// Shared types, microcode codes and residue helpers for the sieve of Atkin engine.
`default_nettype none

package soa_pkg;

    localparam int unsigned MAX_LIMIT_DEF = 65535;
    localparam int unsigned TABLE_AW      = 16;
    localparam int unsigned TABLE_DEPTH   = 1 << TABLE_AW;

    localparam logic [15:0] ADDR_TWO   = 16'd2;
    localparam logic [15:0] ADDR_THREE = 16'd3;

    localparam logic [3:0] RES_BASE = 4'd12;
    localparam logic [3:0] RES_F1A  = 4'd1;
    localparam logic [3:0] RES_F1B  = 4'd5;
    localparam logic [3:0] RES_F2   = 4'd7;
    localparam logic [3:0] RES_F3   = 4'd11;

    localparam logic [8:0]  R_FIRST     = 9'd5;
    localparam logic [16:0] R_FIRST_SQ  = 17'd25;

    typedef enum logic [1:0] {
        ST_BUILD = 2'd0,
        ST_QUERY = 2'd1,
        ST_OOR   = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ADDR_ZERO,
        OP_CLR_WR,
        OP_MARK2,
        OP_MARK3,
        OP_X_INIT,
        OP_X3,
        OP_Y_INIT,
        OP_RD_F1,
        OP_RD_F2,
        OP_RD_F3,
        OP_TOG,
        OP_Y_INC,
        OP_X_INC,
        OP_R_INIT,
        OP_RD_R,
        OP_K_INIT,
        OP_K_CLR,
        OP_R_INC,
        OP_SET_BUILT,
        OP_RD_Q,
        OP_SET_QRES,
        OP_SET_OOR,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_ACCEPT,
        C_QUERY,
        C_OVER,
        C_ADDR_LAST,
        C_F1_OK,
        C_F2_OK,
        C_F3_OK,
        C_X_END,
        C_Y_END,
        C_R_END,
        C_RBIT,
        C_K_END,
        C_Q_OOR,
        C_OUT_BUSY
    } cond_t;

    typedef logic [4:0] pc_t;

    localparam pc_t PC_IDLE       = 5'd0;
    localparam pc_t PC_DISPATCH   = 5'd1;
    localparam pc_t PC_CHK_BUILD  = 5'd2;
    localparam pc_t PC_CLR_INIT   = 5'd3;
    localparam pc_t PC_CLR_LOOP   = 5'd4;
    localparam pc_t PC_MARK2      = 5'd5;
    localparam pc_t PC_MARK3      = 5'd6;
    localparam pc_t PC_X_INIT     = 5'd7;
    localparam pc_t PC_X_TEST     = 5'd8;
    localparam pc_t PC_Y_INIT     = 5'd9;
    localparam pc_t PC_Y_TEST     = 5'd10;
    localparam pc_t PC_F1_RD      = 5'd11;
    localparam pc_t PC_F1_WR      = 5'd12;
    localparam pc_t PC_F2_RD      = 5'd13;
    localparam pc_t PC_F2_WR      = 5'd14;
    localparam pc_t PC_F3_RD      = 5'd15;
    localparam pc_t PC_F3_WR      = 5'd16;
    localparam pc_t PC_Y_NEXT     = 5'd17;
    localparam pc_t PC_X_NEXT     = 5'd18;
    localparam pc_t PC_R_INIT     = 5'd19;
    localparam pc_t PC_R_TEST     = 5'd20;
    localparam pc_t PC_R_CHK      = 5'd21;
    localparam pc_t PC_K_TEST     = 5'd22;
    localparam pc_t PC_K_CLR      = 5'd23;
    localparam pc_t PC_R_NEXT     = 5'd24;
    localparam pc_t PC_BUILD_DONE = 5'd25;
    localparam pc_t PC_Q_RD       = 5'd26;
    localparam pc_t PC_Q_RES      = 5'd27;
    localparam pc_t PC_SET_OOR    = 5'd28;
    localparam pc_t PC_EMIT       = 5'd29;
    localparam pc_t PC_RETURN     = 5'd30;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  inv;
        pc_t   target;
    } ctrl_word_t;

    typedef struct packed {
        logic accept;
        logic is_query;
        logic over;
        logic addr_last;
        logic f1_ok;
        logic f2_ok;
        logic f3_ok;
        logic x_end;
        logic y_end;
        logic r_end;
        logic rbit;
        logic k_end;
        logic q_oor;
        logic out_busy;
    } flags_t;

    function automatic logic [3:0] sq12(input logic [3:0] m);
        logic [3:0] s;
        unique case (m)
            4'd0, 4'd6:               s = 4'd0;
            4'd1, 4'd5, 4'd7, 4'd11:  s = 4'd1;
            4'd2, 4'd4, 4'd8, 4'd10:  s = 4'd4;
            4'd3, 4'd9:               s = 4'd9;
            default:                  s = 4'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] mod12_6(input logic [5:0] val);
        logic [5:0] t;
        t = val;
        if (t >= {RES_BASE, 2'b00})
        begin
            t = t - {RES_BASE, 2'b00};
        end
        if (t >= {1'b0, RES_BASE, 1'b0})
        begin
            t = t - {1'b0, RES_BASE, 1'b0};
        end
        if (t >= {2'b00, RES_BASE})
        begin
            t = t - {2'b00, RES_BASE};
        end
        return t[3:0];
    endfunction

    function automatic logic [3:0] inc12(input logic [3:0] m);
        return (m == RES_F3) ? 4'd0 : m + 4'd1;
    endfunction

endpackage

`default_nettype wire

// ===== design/soa_sequencer.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module soa_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire soa_pkg::flags_t flags,
    output soa_pkg::op_t         op
);
    import soa_pkg::*;

    pc_t        pc_reg;
    pc_t        pc_next;
    ctrl_word_t word;
    logic       cond_val;

    function automatic ctrl_word_t uw(input op_t o, input cond_t c, input logic i,
                                      input pc_t t);
        ctrl_word_t w;
        w.op     = o;
        w.cond   = c;
        w.inv    = i;
        w.target = t;
        return w;
    endfunction

    function automatic ctrl_word_t rom_word(input pc_t pc);
        ctrl_word_t w;
        unique case (pc)
            PC_IDLE:       w = uw(OP_LOAD,      C_ACCEPT,    1'b1, PC_IDLE);
            PC_DISPATCH:   w = uw(OP_NOP,       C_QUERY,     1'b0, PC_Q_RD);
            PC_CHK_BUILD:  w = uw(OP_NOP,       C_OVER,      1'b0, PC_SET_OOR);
            PC_CLR_INIT:   w = uw(OP_ADDR_ZERO, C_NEVER,     1'b0, PC_IDLE);
            PC_CLR_LOOP:   w = uw(OP_CLR_WR,    C_ADDR_LAST, 1'b1, PC_CLR_LOOP);
            PC_MARK2:      w = uw(OP_MARK2,     C_NEVER,     1'b0, PC_IDLE);
            PC_MARK3:      w = uw(OP_MARK3,     C_NEVER,     1'b0, PC_IDLE);
            PC_X_INIT:     w = uw(OP_X_INIT,    C_NEVER,     1'b0, PC_IDLE);
            PC_X_TEST:     w = uw(OP_X3,        C_X_END,     1'b0, PC_R_INIT);
            PC_Y_INIT:     w = uw(OP_Y_INIT,    C_NEVER,     1'b0, PC_IDLE);
            PC_Y_TEST:     w = uw(OP_NOP,       C_Y_END,     1'b0, PC_X_NEXT);
            PC_F1_RD:      w = uw(OP_RD_F1,     C_F1_OK,     1'b1, PC_F2_RD);
            PC_F1_WR:      w = uw(OP_TOG,       C_NEVER,     1'b0, PC_IDLE);
            PC_F2_RD:      w = uw(OP_RD_F2,     C_F2_OK,     1'b1, PC_F3_RD);
            PC_F2_WR:      w = uw(OP_TOG,       C_NEVER,     1'b0, PC_IDLE);
            PC_F3_RD:      w = uw(OP_RD_F3,     C_F3_OK,     1'b1, PC_Y_NEXT);
            PC_F3_WR:      w = uw(OP_TOG,       C_NEVER,     1'b0, PC_IDLE);
            PC_Y_NEXT:     w = uw(OP_Y_INC,     C_ALWAYS,    1'b0, PC_Y_TEST);
            PC_X_NEXT:     w = uw(OP_X_INC,     C_ALWAYS,    1'b0, PC_X_TEST);
            PC_R_INIT:     w = uw(OP_R_INIT,    C_NEVER,     1'b0, PC_IDLE);
            PC_R_TEST:     w = uw(OP_RD_R,      C_R_END,     1'b0, PC_BUILD_DONE);
            PC_R_CHK:      w = uw(OP_K_INIT,    C_RBIT,      1'b1, PC_R_NEXT);
            PC_K_TEST:     w = uw(OP_NOP,       C_K_END,     1'b0, PC_R_NEXT);
            PC_K_CLR:      w = uw(OP_K_CLR,     C_ALWAYS,    1'b0, PC_K_TEST);
            PC_R_NEXT:     w = uw(OP_R_INC,     C_ALWAYS,    1'b0, PC_R_TEST);
            PC_BUILD_DONE: w = uw(OP_SET_BUILT, C_ALWAYS,    1'b0, PC_EMIT);
            PC_Q_RD:       w = uw(OP_RD_Q,      C_Q_OOR,     1'b0, PC_SET_OOR);
            PC_Q_RES:      w = uw(OP_SET_QRES,  C_ALWAYS,    1'b0, PC_EMIT);
            PC_SET_OOR:    w = uw(OP_SET_OOR,   C_NEVER,     1'b0, PC_IDLE);
            PC_EMIT:       w = uw(OP_EMIT,      C_OUT_BUSY,  1'b0, PC_EMIT);
            PC_RETURN:     w = uw(OP_NOP,       C_ALWAYS,    1'b0, PC_IDLE);
            default:       w = uw(OP_NOP,       C_ALWAYS,    1'b0, PC_IDLE);
        endcase
        return w;
    endfunction

    always_comb
    begin
        word = rom_word(pc_reg);
        op   = word.op;
    end

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:     cond_val = 1'b0;
            C_ALWAYS:    cond_val = 1'b1;
            C_ACCEPT:    cond_val = flags.accept;
            C_QUERY:     cond_val = flags.is_query;
            C_OVER:      cond_val = flags.over;
            C_ADDR_LAST: cond_val = flags.addr_last;
            C_F1_OK:     cond_val = flags.f1_ok;
            C_F2_OK:     cond_val = flags.f2_ok;
            C_F3_OK:     cond_val = flags.f3_ok;
            C_X_END:     cond_val = flags.x_end;
            C_Y_END:     cond_val = flags.y_end;
            C_R_END:     cond_val = flags.r_end;
            C_RBIT:      cond_val = flags.rbit;
            C_K_END:     cond_val = flags.k_end;
            C_Q_OOR:     cond_val = flags.q_oor;
            C_OUT_BUSY:  cond_val = flags.out_busy;
            default:     cond_val = 1'b0;
        endcase
        pc_next = (cond_val ^ word.inv) ? word.target : pc_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/soa_datapath.sv =====
// Datapath: flag table, loop counters, quadratic form candidates and result registers.
`default_nettype none

module soa_datapath #(
    parameter int unsigned MAX_LIMIT = soa_pkg::MAX_LIMIT_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire soa_pkg::op_t    op,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire logic            action,
    input  wire logic [15:0]     number,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output logic                 is_prime,
    output logic [1:0]           status,
    output soa_pkg::flags_t      flags
);
    import soa_pkg::*;

    logic flag_mem [TABLE_DEPTH];

    logic        rdata_reg;
    logic        mem_we;
    logic        mem_re;
    logic        mem_wdata;
    logic [TABLE_AW-1:0] mem_addr;

    logic        action_reg,       action_next;
    logic [15:0] number_reg,       number_next;
    logic [15:0] built_limit_reg,  built_limit_next;
    logic        built_valid_reg,  built_valid_next;
    logic [15:0] addr_reg,         addr_next;
    logic [8:0]  x_reg,            x_next;
    logic [8:0]  y_reg,            y_next;
    logic [16:0] xsq_reg,          xsq_next;
    logic [16:0] ysq_reg,          ysq_next;
    logic [17:0] x3sq_reg,         x3sq_next;
    logic [3:0]  xm_reg,           xm_next;
    logic [3:0]  ym_reg,           ym_next;
    logic [8:0]  r_reg,            r_next;
    logic [16:0] rsq_reg,          rsq_next;
    logic [16:0] k_reg,            k_next;
    logic        res_prime_reg,    res_prime_next;
    status_t     res_status_reg,   res_status_next;
    logic        is_prime_reg,     is_prime_next;
    status_t     status_reg,       status_next;
    logic        result_valid_reg, result_valid_next;

    logic        accept;
    logic        out_busy;
    logic [18:0] v1;
    logic [18:0] v2;
    logic [18:0] v3;
    logic [18:0] lim19;
    logic [3:0]  xs;
    logic [3:0]  ys;
    logic [3:0]  r1;
    logic [3:0]  r2;
    logic [3:0]  r3;

    assign item_ready   = (op == OP_LOAD);
    assign accept       = item_valid && item_ready;
    assign out_busy     = result_valid_reg && !result_ready;
    assign result_valid = result_valid_reg;
    assign is_prime     = is_prime_reg;
    assign status       = status_reg;

    always_comb
    begin
        lim19 = {3'b000, number_reg};
        v1    = {xsq_reg, 2'b00} + {2'b00, ysq_reg};
        v2    = {1'b0, x3sq_reg} + {2'b00, ysq_reg};
        v3    = {1'b0, x3sq_reg} - {2'b00, ysq_reg};
        xs    = sq12(xm_reg);
        ys    = sq12(ym_reg);
        r1    = mod12_6({xs, 2'b00} + {2'b00, ys});
        r2    = mod12_6({1'b0, xs, 1'b0} + {2'b00, xs} + {2'b00, ys});
        r3    = mod12_6({1'b0, xs, 1'b0} + {2'b00, xs} + {2'b00, RES_BASE} - {2'b00, ys});
    end

    always_comb
    begin
        flags.accept    = accept;
        flags.is_query  = action_reg;
        flags.over      = (32'(number_reg) > 32'(MAX_LIMIT));
        flags.addr_last = &addr_reg;
        flags.f1_ok     = (v1 <= lim19) && ((r1 == RES_F1A) || (r1 == RES_F1B));
        flags.f2_ok     = (v2 <= lim19) && (r2 == RES_F2);
        flags.f3_ok     = (x_reg > y_reg) && (v3 <= lim19) && (r3 == RES_F3);
        flags.x_end     = (xsq_reg > {1'b0, number_reg});
        flags.y_end     = (ysq_reg > {1'b0, number_reg});
        flags.r_end     = (rsq_reg > {1'b0, number_reg});
        flags.rbit      = rdata_reg;
        flags.k_end     = (k_reg > {1'b0, number_reg});
        flags.q_oor     = (number_reg > built_limit_reg);
        flags.out_busy  = out_busy;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = 1'b0;
        mem_addr  = addr_reg;
        unique case (op)
            OP_CLR_WR:
            begin
                mem_we = 1'b1;
            end
            OP_MARK2:
            begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                mem_addr  = ADDR_TWO;
            end
            OP_MARK3:
            begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                mem_addr  = ADDR_THREE;
            end
            OP_RD_F1:
            begin
                mem_re   = 1'b1;
                mem_addr = v1[TABLE_AW-1:0];
            end
            OP_RD_F2:
            begin
                mem_re   = 1'b1;
                mem_addr = v2[TABLE_AW-1:0];
            end
            OP_RD_F3:
            begin
                mem_re   = 1'b1;
                mem_addr = v3[TABLE_AW-1:0];
            end
            OP_TOG:
            begin
                mem_we    = 1'b1;
                mem_wdata = ~rdata_reg;
            end
            OP_RD_R:
            begin
                mem_re   = 1'b1;
                mem_addr = {7'd0, r_reg};
            end
            OP_K_CLR:
            begin
                mem_we   = 1'b1;
                mem_addr = k_reg[TABLE_AW-1:0];
            end
            OP_RD_Q:
            begin
                mem_re   = 1'b1;
                mem_addr = number_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        action_next       = action_reg;
        number_next       = number_reg;
        built_limit_next  = built_limit_reg;
        built_valid_next  = built_valid_reg;
        addr_next         = addr_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        xsq_next          = xsq_reg;
        ysq_next          = ysq_reg;
        x3sq_next         = x3sq_reg;
        xm_next           = xm_reg;
        ym_next           = ym_reg;
        r_next            = r_reg;
        rsq_next          = rsq_reg;
        k_next            = k_reg;
        res_prime_next    = res_prime_reg;
        res_status_next   = res_status_reg;
        is_prime_next     = is_prime_reg;
        status_next       = status_reg;
        result_valid_next = result_valid_reg && !result_ready;
        unique case (op)
            OP_LOAD:
            begin
                if (accept)
                begin
                    action_next = action;
                    number_next = number;
                end
            end
            OP_ADDR_ZERO:
            begin
                addr_next = '0;
            end
            OP_CLR_WR:
            begin
                addr_next = addr_reg + 16'd1;
            end
            OP_X_INIT:
            begin
                x_next   = 9'd1;
                xsq_next = 17'd1;
                xm_next  = 4'd1;
            end
            OP_X3:
            begin
                x3sq_next = {1'b0, xsq_reg} + {xsq_reg, 1'b0};
            end
            OP_Y_INIT:
            begin
                y_next   = 9'd1;
                ysq_next = 17'd1;
                ym_next  = 4'd1;
            end
            OP_RD_F1:
            begin
                addr_next = v1[TABLE_AW-1:0];
            end
            OP_RD_F2:
            begin
                addr_next = v2[TABLE_AW-1:0];
            end
            OP_RD_F3:
            begin
                addr_next = v3[TABLE_AW-1:0];
            end
            OP_Y_INC:
            begin
                ysq_next = ysq_reg + {7'd0, y_reg, 1'b1};
                y_next   = y_reg + 9'd1;
                ym_next  = inc12(ym_reg);
            end
            OP_X_INC:
            begin
                xsq_next = xsq_reg + {7'd0, x_reg, 1'b1};
                x_next   = x_reg + 9'd1;
                xm_next  = inc12(xm_reg);
            end
            OP_R_INIT:
            begin
                r_next   = R_FIRST;
                rsq_next = R_FIRST_SQ;
            end
            OP_K_INIT:
            begin
                k_next = rsq_reg;
            end
            OP_K_CLR:
            begin
                k_next = k_reg + rsq_reg;
            end
            OP_R_INC:
            begin
                rsq_next = rsq_reg + {7'd0, r_reg, 1'b1};
                r_next   = r_reg + 9'd1;
            end
            OP_SET_BUILT:
            begin
                built_limit_next = number_reg;
                built_valid_next = 1'b1;
                res_prime_next   = 1'b0;
                res_status_next  = ST_BUILD;
            end
            OP_SET_QRES:
            begin
                res_prime_next  = built_valid_reg & rdata_reg;
                res_status_next = ST_QUERY;
            end
            OP_SET_OOR:
            begin
                res_prime_next  = 1'b0;
                res_status_next = ST_OOR;
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    is_prime_next     = res_prime_reg;
                    status_next       = res_status_reg;
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
                addr_next = addr_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            flag_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= flag_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            built_limit_reg  <= '0;
            built_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            built_limit_reg  <= built_limit_next;
            built_valid_reg  <= built_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        number_reg     <= number_next;
        addr_reg       <= addr_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        xsq_reg        <= xsq_next;
        ysq_reg        <= ysq_next;
        x3sq_reg       <= x3sq_next;
        xm_reg         <= xm_next;
        ym_reg         <= ym_next;
        r_reg          <= r_next;
        rsq_reg        <= rsq_next;
        k_reg          <= k_next;
        res_prime_reg  <= res_prime_next;
        res_status_reg <= res_status_next;
        is_prime_reg   <= is_prime_next;
        status_reg     <= status_next;
    end

endmodule

`default_nettype wire

// ===== design/sieve_of_atkin_engine_unit.sv =====
// Top level of the sieve of Atkin engine: sequencer and datapath.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  item     | item_valid / item_ready    | action[0], number[15:0]
//  result   | result_valid / result_ready| is_prime[0], status[1:0]
//
// A query passes from acceptance through dispatch, table read, result step and emit to result valid;
// the next transaction can be taken once a return step has brought the sequencer back to idle.
// A build clears the whole table, marks 2 and 3, toggles the quadratic form candidates up to the limit
// and clears the multiples of each square r*r, r from 5, whose flag is set: one access a cycle to the table.
// After reset the table holds no data; queries before the first build answer not prime.
// A waiting result stalls the sequencer at its emit step; item_ready is high only when idle.
`default_nettype none

module sieve_of_atkin_engine_unit #(
    parameter int unsigned MAX_LIMIT = soa_pkg::MAX_LIMIT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic        action,
    input  wire logic [15:0] number,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic             is_prime,
    output logic [1:0]       status
);
    import soa_pkg::*;

    op_t    op;
    flags_t flags;

    soa_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    soa_datapath #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .number       (number),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_prime     (is_prime),
        .status       (status),
        .flags        (flags)
    );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sieve of Atkin engine: directed and random builds and queries.
module testbench;
    import soa_pkg::*;

    localparam int unsigned TABLE_SIZE  = 65536;
    localparam int unsigned CYCLE_LIMIT = 5000000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned HOLD_AFTER  = 100;
    localparam logic ACT_BUILD = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic        act;
        logic [15:0] num;
    } request_t;

    typedef struct packed {
        logic    prime;
        status_t st;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic        action;
    logic [15:0] number;
    logic        result_valid;
    logic        result_ready;
    logic        is_prime;
    logic [1:0]  status;

    request_t    requests_to_send[$];
    answer_t     answers_due[$];
    bit          sieve_table[TABLE_SIZE];
    int unsigned sieve_limit;

    request_t    head;
    answer_t     due;
    int unsigned errors;
    int unsigned items_taken;
    int unsigned answers_seen;
    int unsigned total_items;
    int unsigned send_gap;
    int unsigned recv_wait;
    int unsigned recv_draw;
    int unsigned long_hold;
    int unsigned cycles;
    bit          item_acc;
    bit          answer_acc;
    bit          quiet;
    bit          hold_done;

    sieve_of_atkin_engine_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .number       (number),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_prime     (is_prime),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int unsigned draw_wait();
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic rebuild_sieve(input int unsigned lim);
        int unsigned x;
        int unsigned y;
        int unsigned r;
        int unsigned k;
        int unsigned v;
        for (int unsigned i = 0; i < TABLE_SIZE; i++)
        begin
            sieve_table[i] = 1'b0;
        end
        sieve_table[2] = 1'b1;
        sieve_table[3] = 1'b1;
        for (x = 1; x * x <= lim; x++)
        begin
            for (y = 1; y * y <= lim; y++)
            begin
                v = 4 * x * x + y * y;
                if (v <= lim && (v % RES_BASE == RES_F1A || v % RES_BASE == RES_F1B))
                begin
                    sieve_table[v] = ~sieve_table[v];
                end
                v = 3 * x * x + y * y;
                if (v <= lim && v % RES_BASE == RES_F2)
                begin
                    sieve_table[v] = ~sieve_table[v];
                end
                if (x > y)
                begin
                    v = 3 * x * x - y * y;
                    if (v <= lim && v % RES_BASE == RES_F3)
                    begin
                        sieve_table[v] = ~sieve_table[v];
                    end
                end
            end
        end
        for (r = 5; r * r <= lim; r++)
        begin
            if (sieve_table[r])
            begin
                for (k = r * r; k <= lim; k += r * r)
                begin
                    sieve_table[k] = 1'b0;
                end
            end
        end
    endtask

    task automatic predict_answer(input request_t rq);
        answer_t a;
        a.prime = 1'b0;
        if (rq.act == ACT_BUILD)
        begin
            if (rq.num > MAX_LIMIT_DEF)
            begin
                a.st = ST_OOR;
            end
            else
            begin
                rebuild_sieve(rq.num);
                sieve_limit = rq.num;
                a.st = ST_BUILD;
            end
        end
        else if (rq.num > sieve_limit)
        begin
            a.st = ST_OOR;
        end
        else
        begin
            a.prime = sieve_table[rq.num];
            a.st = ST_QUERY;
        end
        answers_due = {answers_due, a};
    endtask

    task automatic add_request(input logic act, input int unsigned num);
        request_t rq;
        rq.act = act;
        rq.num = num[15:0];
        requests_to_send = {requests_to_send, rq};
    endtask

    // Record accepted transactions on the item channel and predict their answers
    always @(posedge clk)
    begin
        item_acc <= rst_n && item_valid && item_ready;
        if (rst_n && item_valid && item_ready)
        begin
            head.act = action;
            head.num = number;
            predict_answer(head);
            items_taken++;
        end
    end

    // Drive the item channel
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_acc))
        begin
            if (send_gap != 0)
            begin
                item_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (requests_to_send.size() != 0)
            begin
                head = requests_to_send.pop_front();
                item_valid <= 1'b1;
                action <= head.act;
                number <= head.num;
                send_gap <= draw_wait();
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Check result transactions against the oldest answer due
    always @(posedge clk)
    begin
        answer_acc <= rst_n && result_valid && result_ready;
        if (rst_n && result_valid && result_ready)
        begin
            answers_seen++;
            if (answers_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual is_prime %0b status %0d",
                         $time, is_prime, status);
            end
            else
            begin
                due = answers_due.pop_front();
                if (is_prime !== due.prime)
                begin
                    errors++;
                    $display("%0t: is_prime mismatch: expected %0b, actual %0b",
                             $time, due.prime, is_prime);
                end
                if (status !== due.st)
                begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, due.st, status);
                end
            end
        end
    end

    // Drive result_ready; hold off once for a long stretch to back the block up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold != 0)
            begin
                result_ready <= 1'b0;
                long_hold <= long_hold - 1;
            end
            else if (!hold_done && answers_seen >= HOLD_AFTER)
            begin
                hold_done <= 1'b1;
                long_hold <= LONG_HOLD;
                result_ready <= 1'b0;
            end
            else if (answer_acc)
            begin
                recv_draw = draw_wait();
                if (recv_draw == 0)
                begin
                    result_ready <= 1'b1;
                end
                else
                begin
                    result_ready <= 1'b0;
                    recv_wait <= recv_draw - 1;
                end
            end
            else if (recv_wait != 0)
            begin
                result_ready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles % 256 == 0)
        begin
            quiet <= ($urandom_range(0, 3) == 0);
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned lim;
        int unsigned pick;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        action       = 1'b0;
        number       = 16'd0;
        result_ready = 1'b0;
        sieve_limit  = 0;
        errors       = 0;
        items_taken  = 0;
        answers_seen = 0;
        send_gap     = 0;
        recv_wait    = 0;
        long_hold    = 0;
        cycles       = 0;
        item_acc     = 1'b0;
        answer_acc   = 1'b0;
        quiet        = 1'b0;
        hold_done    = 1'b0;

        // Queries before any build, then tiny limits
        add_request(ACT_QUERY, 0);
        add_request(ACT_QUERY, 1);
        add_request(ACT_QUERY, 65535);
        add_request(ACT_BUILD, 0);
        add_request(ACT_QUERY, 0);
        add_request(ACT_QUERY, 1);
        add_request(ACT_BUILD, 3);
        add_request(ACT_QUERY, 0);
        add_request(ACT_QUERY, 1);
        add_request(ACT_QUERY, 2);
        add_request(ACT_QUERY, 3);
        add_request(ACT_QUERY, 4);
        // Full table
        add_request(ACT_BUILD, 65535);
        add_request(ACT_QUERY, 0);
        add_request(ACT_QUERY, 1);
        add_request(ACT_QUERY, 2);
        add_request(ACT_QUERY, 3);
        add_request(ACT_QUERY, 25);
        add_request(ACT_QUERY, 49);
        add_request(ACT_QUERY, 65521);
        add_request(ACT_QUERY, 65535);
        add_request(ACT_QUERY, 32768);

        for (int i = 0; i < 600; i++)
        begin
            add_request(ACT_QUERY, $urandom_range(0, 65535));
        end
        for (int s = 0; s < 3; s++)
        begin
            lim = $urandom_range(4, 4095);
            add_request(ACT_BUILD, lim);
            for (int i = 0; i < 420; i++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 17)
                begin
                    add_request(ACT_QUERY, $urandom_range(0, lim));
                end
                else if (pick < 19)
                begin
                    add_request(ACT_QUERY, $urandom_range(lim + 1, 65535));
                end
                else
                begin
                    add_request(ACT_QUERY, lim + $urandom_range(0, 1));
                end
            end
        end
        total_items = requests_to_send.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (items_taken < total_items) @(posedge clk);
        while (answers_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/soa_pkg.sv
design/soa_sequencer.sv
design/soa_datapath.sv
design/sieve_of_atkin_engine_unit.sv
test/testbench.sv
